FILE: rtl/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation block.
// Used by the top level only; they expand to nothing when SYNTHESIS is defined.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS
`define MODEXP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("modexp assertion failed");
`define MODEXP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modexp implication failed");
`else
`define MODEXP_ASSERT(lbl, clk, rst_n, prop)
`define MODEXP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/modexp_pkg.sv
// Shared types and constants of the modular exponentiation block.
// No dependencies; used by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

  localparam int OPERAND_BITS = 63;
  localparam int CNT_W        = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_NEXT,
    ST_ACC,
    ST_SQR,
    ST_OUT
  } modexp_state_e;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic run;
    logic done;
  } mm_status_t;

endpackage

FILE: rtl/modexp_mulmod.sv
// Iterative modular multiplier: (x * y) mod m by shift-add-reduce, one
// modular add per cycle. Depends on modexp_pkg.
module modexp_mulmod import modexp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  operand_t   x_i,
  input  operand_t   y_i,
  input  operand_t   m_i,
  output operand_t   result_o,
  output mm_status_t status_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic             add_q, add_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  operand_t         x_q, x_d;
  operand_t         y_q, y_d;
  operand_t         acc_q, acc_d;

  // Shared modular adder: the operands are below m, so one subtract reduces.
  logic [OPERAND_BITS:0]   sum;
  logic [OPERAND_BITS+1:0] diff;
  operand_t                red;

  always_comb begin
    sum  = {1'b0, acc_q} + {1'b0, (add_q ? x_q : acc_q)};
    diff = {1'b0, sum} - {2'b00, m_i};
    red  = diff[OPERAND_BITS+1] ? sum[OPERAND_BITS-1:0] : diff[OPERAND_BITS-1:0];
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    add_d  = add_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      run_d = 1'b1;
      add_d = 1'b0;
      cnt_d = CNT_W'(OPERAND_BITS - 1);
      x_d   = x_i;
      y_d   = y_i;
      acc_d = '0;
    end else if (run_q) begin
      acc_d = red;
      if (!add_q && y_q[OPERAND_BITS-1]) begin
        add_d = 1'b1;
      end else begin
        add_d = 1'b0;
        y_d   = {y_q[OPERAND_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      add_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      add_q  <= add_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign result_o      = acc_q;
  assign status_o.run  = run_q;
  assign status_o.done = done_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply over a shared
// shift-add-reduce multiplier. Each product takes 63 doublings plus one add per
// set multiplier bit. A zero exponent or a modulus of at most one needs no
// product; else the base is reduced, then up to 125 more products follow. One
// item at a time, taken the cycle after the last result is loaded. Reset: async,
// active low.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation import modexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  operand_t base_value_i,
  input  operand_t exponent_value_i,
  input  operand_t modulus_value_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output operand_t power_result_o
);

  modexp_state_e state_q, state_d;
  logic          out_valid_q, out_valid_d;
  operand_t      base_q, base_d;
  operand_t      exp_q, exp_d;
  operand_t      mod_q, mod_d;
  operand_t      acc_q, acc_d;
  operand_t      sq_q, sq_d;
  operand_t      power_q, power_d;

  logic       mm_start;
  operand_t   mm_x, mm_y, mm_result;
  mm_status_t mm_status;

  modexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .x_i      (mm_x),
    .y_i      (mm_y),
    .m_i      (mod_q),
    .result_o (mm_result),
    .status_o (mm_status)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    power_d     = power_q;
    mm_start    = 1'b0;
    mm_x        = sq_q;
    mm_y        = sq_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          base_d  = base_value_i;
          exp_d   = exponent_value_i;
          mod_d   = modulus_value_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (exp_q == '0) begin
          acc_d   = operand_t'(1);
          state_d = ST_OUT;
        end else if (mod_q <= operand_t'(1)) begin
          acc_d   = '0;
          state_d = ST_OUT;
        end else begin
          // Reducing the base is a product with one as multiplicand.
          mm_start = 1'b1;
          mm_x     = operand_t'(1);
          mm_y     = base_q;
          state_d  = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_status.done) begin
          sq_d    = mm_result;
          acc_d   = operand_t'(1);
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        mm_start = 1'b1;
        if (exp_q[0]) begin
          mm_y    = acc_q;
          state_d = ST_ACC;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_ACC: begin
        if (mm_status.done) begin
          acc_d = mm_result;
          if (exp_q[OPERAND_BITS-1:1] == '0) begin
            state_d = ST_OUT;
          end else begin
            mm_start = 1'b1;
            state_d  = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_status.done) begin
          sq_d    = mm_result;
          exp_d   = {1'b0, exp_q[OPERAND_BITS-1:1]};
          state_d = ST_NEXT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          power_d     = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    exp_q   <= exp_d;
    mod_q   <= mod_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    power_q <= power_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = power_q;

  `MODEXP_ASSERT_IMPL(a_start_when_free, clk_i, rst_ni, mm_start, !mm_status.run)
  `MODEXP_ASSERT_IMPL(a_done_when_waiting, clk_i, rst_ni, mm_status.done,
                      (state_q == ST_REDUCE || state_q == ST_ACC || state_q == ST_SQR))
  `MODEXP_ASSERT_IMPL(a_operands_reduced, clk_i, rst_ni,
                      (state_q == ST_NEXT || state_q == ST_ACC || state_q == ST_SQR),
                      (acc_q < mod_q && sq_q < mod_q))
  `MODEXP_ASSERT(a_accept_checks, clk_i, rst_ni,
                 (in_valid_i && !in_stall_o) |=> (state_q == ST_CHECK))

endmodule
